FILE: rtl/coprime_pair_rectangle_count_assert.svh
// Assertion macros used by the checker file.
`ifndef COPRIME_PAIR_RECTANGLE_COUNT_ASSERT_SVH
`define COPRIME_PAIR_RECTANGLE_COUNT_ASSERT_SVH

// An implication that must hold at every clock edge outside reset.
`define CPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cprc_pkg.sv
package cprc_pkg;

    localparam int unsigned MaxN    = 65536;
    localparam int unsigned IdxW    = $clog2(MaxN + 1);
    localparam int unsigned InW     = 17;
    localparam int unsigned OutW    = 33;
    localparam int unsigned SumW    = 2 * IdxW + 3;
    localparam int unsigned EntW    = 3;
    localparam int unsigned ProdW   = 2 * IdxW;
    localparam int unsigned DivCntW = $clog2(IdxW + 1);

    localparam logic [EntW-1:0] EntMarked = 3'b001;
    localparam logic [EntW-1:0] EntSquare = 3'b010;
    localparam logic [EntW-1:0] EntOdd    = 3'b100;

    typedef enum logic [3:0] {
        ST_SIEVE_CLR,
        ST_SIEVE_RD,
        ST_SIEVE_CHK,
        ST_SIEVE_MARK,
        ST_SIEVE_SQ,
        ST_IDLE,
        ST_TERM,
        ST_DIV_RD,
        ST_DIV_WAIT,
        ST_DIV_RUN,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    // Division request and reply to the shared divider.
    typedef struct packed {
        logic            start;
        logic [IdxW-1:0] dividend;
        logic [IdxW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [IdxW-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: rtl/cprc_ram.sv
module cprc_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/cprc_div.sv
module cprc_div
    import cprc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [IdxW-1:0]    r_quo, n_quo;
    logic [IdxW:0]      r_rem, n_rem;
    logic [IdxW-1:0]    r_den, n_den;
    logic [DivCntW-1:0] r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [IdxW:0]      w_trial;

    // One quotient bit per cycle, restoring division.
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[IdxW-1:0], r_quo[IdxW-1]};
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_den  = i_req.divisor;
            n_cnt  = DivCntW'(IdxW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_quo = {r_quo[IdxW-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[IdxW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DivCntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

FILE: rtl/coprime_pair_rectangle_count.sv
// Coprime pair rectangle counter. After reset the block runs a sieve over
// 2..MaxN into a Mobius table held in a RAM, and the block does not accept
// a query transaction until it has finished. A query transaction gives the
// bounds a..b and c..d, and the block returns one result transaction with
// the number of coprime pairs in that rectangle, formed as four prefix
// counts f(b,d) + f(a-1,c-1) - f(b,c-1) - f(a-1,d). Each prefix count walks
// its divisors one at a time; a divisor with a square factor is skipped,
// while a squarefree divisor costs two divisions on the shared bit-serial
// divider and a multiply and accumulate. An inverted range is flagged with
// bad_range and answered at once with a count of zero.
module coprime_pair_rectangle_count
    import cprc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [InW-1:0]  i_first_low,
    input  logic [InW-1:0]  i_first_high,
    input  logic [InW-1:0]  i_second_low,
    input  logic [InW-1:0]  i_second_high,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [OutW-1:0] o_pair_count,
    output logic            o_bad_range
);
    t_state r_state, n_state;

    // Sieve indices: the prime being swept and the multiple being written.
    logic [IdxW:0]     r_p, n_p;
    logic [IdxW:0]     r_j, n_j;
    // Query bounds after clamping.
    logic [IdxW-1:0]   r_a1, n_a1, r_b, n_b, r_c1, n_c1, r_d, n_d;
    logic [1:0]        r_term, n_term;
    logic [IdxW-1:0]   r_x, n_x, r_y, n_y, r_m, n_m;
    logic [IdxW:0]     r_i, n_i;
    logic              r_second, n_second;
    logic [IdxW-1:0]   r_qx, n_qx, r_qy, n_qy;
    logic [ProdW-1:0]  r_prod, n_prod;
    logic              r_odd, n_odd;
    logic signed [SumW-1:0] r_run, n_run, r_total, n_total;
    logic              r_ovalid, n_ovalid;
    logic [OutW-1:0]   r_count, n_count;
    logic              r_bad, n_bad;

    // RAM port and divider.
    logic              w_we;
    logic [IdxW-1:0]   w_waddr, w_raddr;
    logic [EntW-1:0]   w_wdata, w_rdata;
    t_div_req          w_req;
    t_div_rsp          w_rsp;

    logic              w_accept;
    logic [2*IdxW+1:0] w_sq;
    logic [IdxW-1:0]   w_tx, w_ty;

    assign w_accept = i_valid && !o_stall;
    assign w_sq     = r_p * r_p;

    cprc_ram #(.Width(EntW), .Depth(2 ** IdxW)) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    cprc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // Operands of each of the four prefix counts.
    always_comb begin
        case (r_term)
            2'd0:    begin w_tx = r_b;  w_ty = r_d;  end
            2'd1:    begin w_tx = r_a1; w_ty = r_c1; end
            2'd2:    begin w_tx = r_b;  w_ty = r_c1; end
            default: begin w_tx = r_a1; w_ty = r_d;  end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SIEVE_CLR:  if (r_j == (IdxW + 1)'(2 ** IdxW - 1)) n_state = ST_SIEVE_RD;
            ST_SIEVE_RD:   n_state = (r_p > (IdxW + 1)'(MaxN)) ? ST_IDLE : ST_SIEVE_CHK;
            ST_SIEVE_CHK:  n_state = w_rdata[0] ? ST_SIEVE_RD : ST_SIEVE_MARK;
            ST_SIEVE_MARK: if (r_j > (IdxW + 1)'(MaxN)) n_state = ST_SIEVE_SQ;
            ST_SIEVE_SQ:   if (r_j > (IdxW + 1)'(MaxN)) n_state = ST_SIEVE_RD;
            ST_IDLE:       if (w_accept) n_state = ST_TERM;
            ST_TERM:       n_state = ST_DIV_RD;
            ST_DIV_RD:     n_state = (r_i > {1'b0, r_m}) ? ST_ACC : ST_DIV_WAIT;
            ST_DIV_WAIT:   n_state = w_rdata[1] ? ST_DIV_RD : ST_DIV_RUN;
            ST_DIV_RUN:    if (w_rsp.done && r_second) n_state = ST_MUL;
            ST_MUL:        n_state = ST_DIV_RD;
            ST_ACC:        n_state = (r_term == 2'd3) ? ST_DONE : ST_TERM;
            ST_DONE:       n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
        if (r_state == ST_IDLE && w_accept) begin
            if (i_first_low > i_first_high || i_second_low > i_second_high ||
                n_a1 >= n_b || n_c1 >= n_d) begin
                n_state = ST_IDLE;
            end
        end
    end

    // Datapath and outputs.
    always_comb begin
        n_p = r_p; n_j = r_j;
        n_a1 = r_a1; n_b = r_b; n_c1 = r_c1; n_d = r_d;
        n_term = r_term; n_x = r_x; n_y = r_y; n_m = r_m; n_i = r_i;
        n_second = r_second; n_qx = r_qx; n_qy = r_qy; n_prod = r_prod;
        n_odd = r_odd; n_run = r_run; n_total = r_total;
        n_ovalid = r_ovalid; n_count = r_count; n_bad = r_bad;
        w_we = 1'b0; w_waddr = r_j[IdxW-1:0]; w_wdata = '0;
        w_raddr = r_p[IdxW-1:0];
        w_req = '0;
        o_stall = (r_state != ST_IDLE) || r_ovalid;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;

        // Clamped bounds of the incoming query, minus one on the low side.
        n_a1 = (i_first_low == '0) ? '0 : IdxW'(i_first_low - 1'b1);
        n_c1 = (i_second_low == '0) ? '0 : IdxW'(i_second_low - 1'b1);
        n_b  = (i_first_high > InW'(MaxN)) ? IdxW'(MaxN) : IdxW'(i_first_high);
        n_d  = (i_second_high > InW'(MaxN)) ? IdxW'(MaxN) : IdxW'(i_second_high);
        if (!(r_state == ST_IDLE && w_accept)) begin
            n_a1 = r_a1; n_b = r_b; n_c1 = r_c1; n_d = r_d;
        end

        case (r_state)
            ST_SIEVE_CLR: begin
                w_we = 1'b1;
                n_j  = r_j + 1'b1;
                n_p  = (IdxW + 1)'(2);
            end
            ST_SIEVE_RD: begin
                n_j = r_p;
            end
            ST_SIEVE_CHK: begin
                w_raddr = r_j[IdxW-1:0];
                if (w_rdata[0]) n_p = r_p + 1'b1;
            end
            ST_SIEVE_MARK: begin
                // Read-modify-write: the read is issued while r_second is clear,
                // and the updated entry is written once r_second is set.
                w_raddr = r_j[IdxW-1:0];
                if (r_j <= (IdxW + 1)'(MaxN)) begin
                    if (r_second) begin
                        w_we = 1'b1;
                        w_wdata = (w_rdata ^ EntOdd) | EntMarked;
                        n_j = r_j + r_p;
                    end
                    n_second = !r_second;
                end else begin
                    // A square beyond the table skips the square sweep.
                    n_second = 1'b0;
                    n_j = (w_sq > (2 * IdxW + 2)'(MaxN)) ? (IdxW + 1)'(MaxN + 1)
                                                         : w_sq[IdxW:0];
                end
            end
            ST_SIEVE_SQ: begin
                w_raddr = r_j[IdxW-1:0];
                if (r_j <= (IdxW + 1)'(MaxN)) begin
                    if (r_second) begin
                        w_we = 1'b1;
                        w_wdata = w_rdata | EntSquare;
                        n_j = r_j + w_sq[IdxW:0];
                    end
                    n_second = !r_second;
                end else begin
                    n_j = (IdxW + 1)'(MaxN + 1);
                    n_second = 1'b0;
                    n_p = r_p + 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_term  = 2'd0;
                    n_total = '0;
                    if (i_first_low > i_first_high || i_second_low > i_second_high) begin
                        n_ovalid = 1'b1; n_count = '0; n_bad = 1'b1;
                    end else if (n_a1 >= n_b || n_c1 >= n_d) begin
                        n_ovalid = 1'b1; n_count = '0; n_bad = 1'b0;
                    end
                end
            end
            ST_TERM: begin
                n_x = w_tx; n_y = w_ty;
                n_m = (w_tx < w_ty) ? w_tx : w_ty;
                n_run = SumW'($signed({1'b0, ProdW'(w_tx) * ProdW'(w_ty)}));
                n_i = (IdxW + 1)'(2);
            end
            ST_DIV_RD: begin
                w_raddr = r_i[IdxW-1:0];
                n_second = 1'b0;
            end
            ST_DIV_WAIT: begin
                w_raddr = r_i[IdxW-1:0];
                n_odd = w_rdata[2];
                if (w_rdata[1]) begin
                    n_i = r_i + 1'b1;
                end else begin
                    w_req.start = 1'b1;
                    w_req.dividend = r_x;
                    w_req.divisor = r_i[IdxW-1:0];
                end
            end
            ST_DIV_RUN: begin
                if (w_rsp.done) begin
                    if (!r_second) begin
                        n_qx = w_rsp.quotient;
                        n_second = 1'b1;
                        w_req.start = 1'b1;
                        w_req.dividend = r_y;
                        w_req.divisor = r_i[IdxW-1:0];
                    end else begin
                        n_qy = w_rsp.quotient;
                    end
                end
            end
            ST_MUL: begin
                n_prod = r_qx * r_qy;
                n_i = r_i + 1'b1;
            end
            ST_ACC: begin
                case (r_term)
                    2'd0, 2'd1: n_total = r_total + r_run;
                    default:    n_total = r_total - r_run;
                endcase
                n_term = r_term + 1'b1;
            end
            ST_DONE: begin
                n_ovalid = 1'b1;
                n_bad = 1'b0;
                n_count = (r_total < 0) ? '0 : OutW'(r_total);
            end
            default: ;
        endcase

        // The product of the previous divisor is folded in when the walk returns to ST_DIV_RD.
        if (r_state == ST_DIV_RD && r_i > (IdxW + 1)'(2) && r_second) begin
            n_run = r_odd ? r_run - SumW'($signed({1'b0, r_prod}))
                          : r_run + SumW'($signed({1'b0, r_prod}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_SIEVE_CLR;
            r_ovalid <= 1'b0;
            r_j      <= '0;
            r_p      <= (IdxW + 1)'(2);
            r_second <= 1'b0;
            r_term   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_j      <= n_j;
            r_p      <= n_p;
            r_second <= n_second;
            r_term   <= n_term;
        end
        r_a1 <= n_a1; r_b <= n_b; r_c1 <= n_c1; r_d <= n_d;
        r_x <= n_x; r_y <= n_y; r_m <= n_m; r_i <= n_i;
        r_qx <= n_qx; r_qy <= n_qy; r_prod <= n_prod; r_odd <= n_odd;
        r_run <= n_run; r_total <= n_total;
        r_count <= n_count; r_bad <= n_bad;
    end

    assign o_valid      = r_ovalid;
    assign o_pair_count = r_count;
    assign o_bad_range  = r_bad;
endmodule

FILE: rtl/cprc_checker.sv
`include "coprime_pair_rectangle_count_assert.svh"

module cprc_checker
    import cprc_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic [OutW-1:0] o_pair_count,
    input logic            o_bad_range
);
    `CPR_ASSERT_IMPL(a_bad_zero, i_clk, i_rst_n, o_valid && o_bad_range,
        o_pair_count == '0, "flagged range with nonzero count")
    `CPR_ASSERT_IMPL(a_busy_out, i_clk, i_rst_n, o_valid, o_stall,
        "query taken while result pending")
    `CPR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_pair_count), "stalled result changed")
endmodule

bind coprime_pair_rectangle_count cprc_checker u_cprc_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

// Testbench for the coprime pair rectangle counter.
//
// A small scoreboard class keeps its own Mobius table, built by a sieve at
// time zero. For every query transaction that the block accepts, it works
// out the expected count and flag by inclusion and exclusion over four
// prefix counts. Each result transaction is then checked against the
// oldest expectation in the queue.
//
// A query costs the block work for every divisor up to the smaller of the
// two bounds of each prefix count. Every well-formed query therefore keeps
// one side of the rectangle small, while the other side spans the full
// 17-bit field. The full field includes values above MaxN, which the block
// saturates. Noise queries are inverted ranges, which cost nothing and
// exercise the flag.
module testbench;
    import cprc_pkg::*;

    typedef logic [InW-1:0]  t_bound;
    typedef logic [OutW-1:0] t_count;

    // Holds the Mobius table and the queue of expected result transactions.
    class pair_count_board;
        bit     marked[];
        bit     square[];
        bit     odd[];
        t_count count_q[$];
        bit     flag_q[$];
        t_count want_count;
        bit     want_flag;

        function new();
            longint unsigned i, j;
            marked = new[MaxN + 1];
            square = new[MaxN + 1];
            odd    = new[MaxN + 1];
            for (i = 2; i <= MaxN; i++) begin
                if (!marked[i]) begin
                    for (j = i; j <= MaxN; j += i) begin
                        odd[j]    = !odd[j];
                        marked[j] = 1'b1;
                    end
                    for (j = i * i; j <= MaxN; j += i * i)
                        square[j] = 1'b1;
                end
            end
        endfunction

        // Coprime pairs in 1..x by 1..y.
        function longint coprime_below(longint x, longint y);
            longint acc, lim, k, t;
            acc = x * y;
            lim = (x < y) ? x : y;
            for (k = 2; k <= lim; k++) begin
                if (!square[k]) begin
                    t = (x / k) * (y / k);
                    acc = odd[k] ? acc - t : acc + t;
                end
            end
            return acc;
        endfunction

        function void note_query(t_bound a_in, t_bound b_in, t_bound c_in, t_bound d_in);
            longint a, b, c, d, total;
            a = a_in;
            b = b_in;
            c = c_in;
            d = d_in;
            if (a > b || c > d) begin
                count_q.push_back('0);
                flag_q.push_back(1'b1);
                return;
            end
            if (a == 0) a = 1;
            if (c == 0) c = 1;
            if (b > MaxN) b = MaxN;
            if (d > MaxN) d = MaxN;
            if (a > b || c > d) begin
                count_q.push_back('0);
                flag_q.push_back(1'b0);
                return;
            end
            total = coprime_below(b, d) + coprime_below(a - 1, c - 1)
                  - coprime_below(b, c - 1) - coprime_below(a - 1, d);
            if (total < 0) total = 0;
            count_q.push_back(t_count'(total));
            flag_q.push_back(1'b0);
        endfunction

        // 0: match, 1: nothing expected, 2: field mismatch.
        function int check_result(t_count got_count, bit got_flag);
            if (count_q.size() == 0) return 1;
            want_count = count_q.pop_front();
            want_flag  = flag_q.pop_front();
            if (got_count !== want_count || got_flag !== want_flag) return 2;
            return 0;
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_stall;
    t_bound i_first_low = '0;
    t_bound i_first_high = '0;
    t_bound i_second_low = '0;
    t_bound i_second_high = '0;
    logic   o_valid;
    logic   i_stall = 1'b0;
    t_count o_pair_count;
    logic   o_bad_range;

    pair_count_board board;
    int  mismatches = 0;
    // While set, neither side idles nor stalls.
    bit  calm = 1'b0;

    always #4 i_clk = ~i_clk;

    coprime_pair_rectangle_count u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_first_low  (i_first_low),
        .i_first_high (i_first_high),
        .i_second_low (i_second_low),
        .i_second_high(i_second_high),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pair_count (o_pair_count),
        .o_bad_range  (o_bad_range)
    );

    task automatic report(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Offers one query transaction and holds it until the block takes it.
    task automatic send_query(t_bound a, t_bound b, t_bound c, t_bound d);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 16) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_first_low   = a;
        i_first_high  = b;
        i_second_low  = c;
        i_second_high = d;
        do @(posedge i_clk); while (o_stall);
        board.note_query(a, b, c, d);
    endtask

    // A rectangle with one short side and one side across the full field.
    task automatic send_random_query();
        t_bound lo_s, hi_s, lo_w, hi_w, t;
        hi_s = t_bound'(($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(40));
        lo_s = t_bound'($urandom_range(hi_s));
        hi_w = t_bound'($urandom_range((1 << InW) - 1));
        lo_w = t_bound'($urandom_range(hi_w));
        if ($urandom_range(99) < 20) begin
            // Inverted range on one or both sides, with random content.
            lo_w = t_bound'($urandom_range((1 << InW) - 1));
            hi_w = t_bound'($urandom_range((1 << InW) - 1));
            if (lo_w == hi_w) hi_w = lo_w - 1'b1;
            if (lo_w < hi_w) begin
                t = lo_w;
                lo_w = hi_w;
                hi_w = t;
            end
            lo_s = t_bound'($urandom_range((1 << InW) - 1));
            hi_s = t_bound'($urandom_range((1 << InW) - 1));
        end
        if ($urandom_range(1))
            send_query(lo_w, hi_w, lo_s, hi_s);
        else
            send_query(lo_s, hi_s, lo_w, hi_w);
    endtask

    // The receiving side stalls at random outside the calm stretch.
    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 16);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            case (board.check_result(o_pair_count, o_bad_range))
                1: report($sformatf("result %0d/%0d with nothing expected",
                                    o_pair_count, o_bad_range));
                2: report($sformatf("got count %0d flag %0d, expected %0d/%0d",
                                    o_pair_count, o_bad_range,
                                    board.want_count, board.want_flag));
                default: ;
            endcase
        end
    end

    initial begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed cases: the smallest and largest bounds, both inverted
        // ranges, zero low bounds, saturation above MaxN, and a rectangle
        // that becomes empty only once it has been saturated.
        send_query(1, 1, 1, 1);
        send_query(1, t_bound'(MaxN), 1, 1);
        send_query(1, 1, 1, t_bound'(MaxN));
        send_query(5, 3, 1, 2);
        send_query(1, 2, 9, 4);
        send_query('1, '0, '1, '0);
        send_query(0, 12, 0, 7);
        send_query(0, 0, 0, 5);
        send_query(3, 9, 0, 0);
        send_query(1, '1, 1, 10);
        send_query(70000, '1, 1, 5);
        send_query('1, '1, '1, '1);
        send_query(t_bound'(MaxN), t_bound'(MaxN), 1, 3);
        send_query(2, 10, 3, 12);
        send_query(100, 200, 50, 60);
        send_query(1, 40, 1, 40);

        for (int n = 0; n < 100; n++) begin
            calm = (n >= 40 && n < 70);
            send_random_query();
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_valid = 1'b0;

        while (board.count_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
